// File: sv/rstm_pkg.sv
// Shared codes, reset values and widths for the radio silence tamper monitor.
`default_nettype none

package rstm_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Alert kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_WIFI = 2'd1;
    localparam logic [1:0] KIND_BLE  = 2'd2;
    localparam logic [1:0] KIND_BOTH = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_WIFI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_BLE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_HOLDOFF      = 3'd4;

    // Register reset values.
    localparam logic [31:0] SILENCE_THRESHOLD_RST = 32'd300000;
    localparam logic [31:0] CHECK_INTERVAL_RST    = 32'd30000;
    localparam logic [31:0] BOOT_HOLDOFF_RST      = 32'd120000;

    // Widths of the stream payloads.
    localparam int unsigned SECS_W   = 23;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 64;

    // Bit positions inside the result tdata.
    localparam int unsigned M_RAN_BIT    = 0;
    localparam int unsigned M_RAISED_BIT = 1;
    localparam int unsigned M_ON_BIT     = 2;
    localparam int unsigned M_KIND_LSB   = 3;
    localparam int unsigned M_SECS_LSB   = 5;
    localparam int unsigned M_EPOCH_LSB  = 28;
    localparam int unsigned M_EVER_BIT   = 60;

endpackage

`default_nettype wire

// File: sv/radio_silence_tamper_monitor.sv
// Top level of the radio silence tamper monitor: input register, one-pass update, result register.
// An accepted item waits in the input register and is loaded into the result register when
// it advances; its result item is then offered on the result stream until it is taken.
// Throughput: one item per cycle while results are taken, set by the one-pass state update.
// The item in the input register advances whenever the result register is empty or being taken.
// Reset: synchronous, active-low aresetn clears both valid flags, the monitor state and loads
// the configuration registers with their default values.
`default_nettype none

module radio_silence_tamper_monitor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0 up: now_ms[31:0], epoch_s[31:0], wifi_active, wifi_seen,
    // ble_active, ble_seen, then four zero bits.
    input  wire logic [rstm_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: op[1:0].
    input  wire logic [rstm_pkg::S_USER_W-1:0] s_tuser,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0 up: check_ran, alert_raised, alert_on, alert_kind[1:0],
    // silence_seconds[22:0], alert_epoch[31:0], ever_published, then three zero bits.
    output logic [rstm_pkg::M_DATA_W-1:0] m_tdata,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [rstm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Divides a millisecond span by 1000 with a reciprocal multiply. The constant is
    // ceil(2^38 / 1000); its error stays below one unit for every 32-bit operand.
    function automatic logic [rstm_pkg::SECS_W-1:0] ms_to_secs(input logic [31:0] ms);
        logic [60:0] prod;
        prod = {29'd0, ms} * 61'd274877907;
        return prod[60:38];
    endfunction

    // Configuration registers. The channel never stalls.
    logic [31:0] thr_reg, interval_reg, holdoff_reg;
    logic        watch_wifi_reg, watch_ble_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= rstm_pkg::SILENCE_THRESHOLD_RST;
            interval_reg   <= rstm_pkg::CHECK_INTERVAL_RST;
            watch_wifi_reg <= 1'b1;
            watch_ble_reg  <= 1'b1;
            holdoff_reg    <= rstm_pkg::BOOT_HOLDOFF_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                rstm_pkg::REG_SILENCE_THRESHOLD: thr_reg        <= cfg_data;
                rstm_pkg::REG_CHECK_INTERVAL:    interval_reg   <= cfg_data;
                rstm_pkg::REG_WATCH_WIFI:        watch_wifi_reg <= cfg_data[0];
                rstm_pkg::REG_WATCH_BLE:         watch_ble_reg  <= cfg_data[0];
                rstm_pkg::REG_BOOT_HOLDOFF:      holdoff_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register. It takes a new item when it is empty or its current content moves on in
    // the same cycle, so the two sides are decoupled by one stage.
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [31:0] now_reg, epoch_reg;
    logic        wa_reg, ws_reg, ba_reg, bs_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg    <= s_tuser;
            now_reg   <= s_tdata[31:0];
            epoch_reg <= s_tdata[63:32];
            wa_reg    <= s_tdata[64];
            ws_reg    <= s_tdata[65];
            ba_reg    <= s_tdata[66];
            bs_reg    <= s_tdata[67];
        end
    end

    // Monitor state.
    logic        running_reg, running_next;
    logic [31:0] last_check_reg, last_check_next;
    logic [31:0] wifi_seen_t_reg, wifi_seen_t_next;
    logic [31:0] ble_seen_t_reg, ble_seen_t_next;
    logic        wifi_sent_reg, wifi_sent_next;
    logic        ble_sent_reg, ble_sent_next;
    logic        active_reg, active_next;
    logic [1:0]  kind_reg, kind_next;
    logic [rstm_pkg::SECS_W-1:0] silence_reg, silence_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        published_reg, published_next;

    // Check evaluation. A check is due on the first check after start (last check time
    // of zero) or once the wrapped distance to the last check reaches the interval.
    logic        is_check, due, evaluate;
    logic [31:0] check_gap, wifi_gap, ble_gap;
    logic        wifi_on, ble_on;
    logic        wifi_refresh, ble_refresh;
    logic        wifi_mute, ble_mute;
    logic        wifi_sent_mid, ble_sent_mid;
    logic [rstm_pkg::SECS_W-1:0] wifi_secs, ble_secs, max_secs;
    logic [1:0]  kind_now;
    logic        raise;

    assign is_check  = (op_reg == rstm_pkg::OP_CHECK) && running_reg;
    assign check_gap = now_reg - last_check_reg;
    assign due       = (last_check_reg == 32'd0) || (check_gap >= interval_reg);
    assign evaluate  = is_check && due && (now_reg >= holdoff_reg);

    assign wifi_on = watch_wifi_reg && wa_reg;
    assign ble_on  = watch_ble_reg && ba_reg;
    assign wifi_gap = now_reg - wifi_seen_t_reg;
    assign ble_gap  = now_reg - ble_seen_t_reg;

    // A channel that reports devices refreshes; one that reports none may be silent.
    assign wifi_refresh = evaluate && wifi_on && ws_reg;
    assign ble_refresh  = evaluate && ble_on && bs_reg;
    assign wifi_mute    = evaluate && wifi_on && !ws_reg && (wifi_gap >= thr_reg);
    assign ble_mute     = evaluate && ble_on && !bs_reg && (ble_gap >= thr_reg);

    assign wifi_secs = ms_to_secs(wifi_gap);
    assign ble_secs  = ms_to_secs(ble_gap);

    assign wifi_sent_mid = wifi_refresh ? 1'b0 : wifi_sent_reg;
    assign ble_sent_mid  = ble_refresh ? 1'b0 : ble_sent_reg;

    assign kind_now = {ble_mute, wifi_mute};

    always_comb begin
        case (kind_now)
            rstm_pkg::KIND_WIFI: begin
                max_secs = wifi_secs;
                raise    = !wifi_sent_mid;
            end
            rstm_pkg::KIND_BLE: begin
                max_secs = ble_secs;
                raise    = !ble_sent_mid;
            end
            rstm_pkg::KIND_BOTH: begin
                max_secs = (wifi_secs > ble_secs) ? wifi_secs : ble_secs;
                raise    = !wifi_sent_mid || !ble_sent_mid;
            end
            default: begin
                max_secs = '0;
                raise    = 1'b0;
            end
        endcase
    end

    // Next-state selection for the item in the input register.
    always_comb begin
        running_next     = running_reg;
        last_check_next  = last_check_reg;
        wifi_seen_t_next = wifi_seen_t_reg;
        ble_seen_t_next  = ble_seen_t_reg;
        wifi_sent_next   = wifi_sent_reg;
        ble_sent_next    = ble_sent_reg;
        active_next      = active_reg;
        kind_next        = kind_reg;
        silence_next     = silence_reg;
        stamp_next       = stamp_reg;
        published_next   = published_reg;
        case (op_reg)
            rstm_pkg::OP_START: begin
                // A start while already running changes nothing.
                if (!running_reg) begin
                    running_next     = 1'b1;
                    active_next      = 1'b0;
                    kind_next        = rstm_pkg::KIND_NONE;
                    silence_next     = '0;
                    stamp_next       = '0;
                    published_next   = 1'b0;
                    wifi_seen_t_next = now_reg;
                    ble_seen_t_next  = now_reg;
                end
            end
            rstm_pkg::OP_CLEAR: begin
                active_next    = 1'b0;
                kind_next      = rstm_pkg::KIND_NONE;
                wifi_sent_next = 1'b0;
                ble_sent_next  = 1'b0;
            end
            rstm_pkg::OP_CHECK: begin
                // The holdoff skip still moves the last check time.
                if (is_check && due) begin
                    last_check_next = now_reg;
                end
                if (wifi_refresh) begin
                    wifi_seen_t_next = now_reg;
                end
                if (ble_refresh) begin
                    ble_seen_t_next = now_reg;
                end
                wifi_sent_next = (raise && kind_now[0]) ? 1'b1 : wifi_sent_mid;
                ble_sent_next  = (raise && kind_now[1]) ? 1'b1 : ble_sent_mid;
                if (kind_now != rstm_pkg::KIND_NONE) begin
                    kind_next    = kind_now;
                    silence_next = max_secs;
                    stamp_next   = epoch_reg;
                    active_next  = 1'b1;
                    if (raise) begin
                        published_next = 1'b1;
                    end
                end else if (evaluate && active_reg) begin
                    // Recovery drops the active alert.
                    active_next = 1'b0;
                    kind_next   = rstm_pkg::KIND_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg     <= 1'b0;
            last_check_reg  <= '0;
            wifi_seen_t_reg <= '0;
            ble_seen_t_reg  <= '0;
            wifi_sent_reg   <= 1'b0;
            ble_sent_reg    <= 1'b0;
            active_reg      <= 1'b0;
            kind_reg        <= rstm_pkg::KIND_NONE;
            silence_reg     <= '0;
            stamp_reg       <= '0;
            published_reg   <= 1'b0;
        end else if (advance) begin
            running_reg     <= running_next;
            last_check_reg  <= last_check_next;
            wifi_seen_t_reg <= wifi_seen_t_next;
            ble_seen_t_reg  <= ble_seen_t_next;
            wifi_sent_reg   <= wifi_sent_next;
            ble_sent_reg    <= ble_sent_next;
            active_reg      <= active_next;
            kind_reg        <= kind_next;
            silence_reg     <= silence_next;
            stamp_reg       <= stamp_next;
            published_reg   <= published_next;
        end
    end

    // Result register. The kind reads as none while no alert is active.
    logic [rstm_pkg::M_DATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'd0, published_next, stamp_next, silence_next,
                             active_next ? kind_next : rstm_pkg::KIND_NONE,
                             active_next, raise, evaluate};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: sv/rstm_checker.sv
// Port-level checker for the radio silence tamper monitor and its bind.
`default_nettype none

module rstm_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [rstm_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result item keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // The result stream is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A raised alert comes from an evaluated check, is active, has a kind and is marked published.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[rstm_pkg::M_RAISED_BIT] |->
            m_tdata[rstm_pkg::M_RAN_BIT] && m_tdata[rstm_pkg::M_ON_BIT] &&
            m_tdata[rstm_pkg::M_EVER_BIT] &&
            (m_tdata[rstm_pkg::M_KIND_LSB +: 2] != rstm_pkg::KIND_NONE))
        else $error("raised alert without active kind or published mark");

    // With no active alert the kind reads as none.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[rstm_pkg::M_ON_BIT] |->
            (m_tdata[rstm_pkg::M_KIND_LSB +: 2] == rstm_pkg::KIND_NONE))
        else $error("kind shown while no alert is active");

    // The input side is never refused while both stages are free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with an empty pipeline");

endmodule

bind radio_silence_tamper_monitor rstm_checker u_rstm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/tb_radio_silence_tamper_monitor.sv
// Testbench for the radio silence tamper monitor: a directed table, then randomized phases.
`default_nettype none

module tb_radio_silence_tamper_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    // Op code 3 has no function in the block; it must leave every piece of state alone.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam int unsigned HALF_PERIOD    = 5;
    localparam int unsigned RESET_CYCLES   = 7;
    // Two register stages between input and result, plus some margin.
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MS_PER_SECOND  = 1000;

    // One input item as the scanners and the timer deliver it.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [31:0] epoch_s;
        logic        wifi_active;
        logic        wifi_seen;
        logic        ble_active;
        logic        ble_seen;
    } radio_item_t;

    // One result item: the status reported after each input item.
    typedef struct packed {
        logic        ran;
        logic        raised;
        logic        on;
        logic [1:0]  kind;
        logic [22:0] secs;
        logic [31:0] epoch;
        logic        ever;
    } monitor_status_t;

    // A row of the directed table. Rows with has_want set carry a status typed in by hand;
    // the others are checked against the predictor.
    typedef struct packed {
        radio_item_t     stim;
        logic            has_want;
        monitor_status_t want;
    } table_row_t;

    // Clock, reset and the ports of the block. Every input starts at a known value.
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [rstm_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic [rstm_pkg::S_USER_W-1:0]   s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [rstm_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rstm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]                     cfg_data  = '0;

    // The predictor's copy of the configuration, starting from the reset values.
    logic [31:0] cfg_threshold  = rstm_pkg::SILENCE_THRESHOLD_RST;
    logic [31:0] cfg_interval   = rstm_pkg::CHECK_INTERVAL_RST;
    logic        cfg_watch_wifi = 1'b1;
    logic        cfg_watch_ble  = 1'b1;
    logic [31:0] cfg_holdoff    = rstm_pkg::BOOT_HOLDOFF_RST;

    // The predictor's copy of the monitor state, also at its reset values.
    logic        st_running    = 1'b0;
    logic [31:0] st_last_check = '0;
    logic [31:0] st_wifi_last  = '0;
    logic [31:0] st_ble_last   = '0;
    logic        st_wifi_sent  = 1'b0;
    logic        st_ble_sent   = 1'b0;
    logic        st_active     = 1'b0;
    logic [1:0]  st_kind       = rstm_pkg::KIND_NONE;
    logic [22:0] st_silence    = '0;
    logic [31:0] st_epoch      = '0;
    logic        st_published  = 1'b0;

    // Statuses predicted for accepted items, oldest first.
    monitor_status_t expected_status[$];
    table_row_t      stimulus_table[$];

    int unsigned error_count      = 0;
    int unsigned items_sent       = 0;
    int unsigned results_checked  = 0;
    int unsigned checks_evaluated = 0;
    int unsigned alerts_raised    = 0;
    int unsigned settings_used    = 1;
    int unsigned burst_left       = 0;
    int unsigned idle_cycles      = 0;
    logic [31:0] rx_cycle         = '0;

    // Scanner behavior of the random part: a quiet scanner reports devices only rarely,
    // which lets silence build up over many checks.
    logic [31:0] clock_ms   = '0;
    logic        wifi_quiet = 1'b0;
    logic        ble_quiet  = 1'b0;

    radio_silence_tamper_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Every mismatch goes through here: one line each, and the count.
    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   results_checked, field, got, want));
    endtask

    // Looks at one scanner during an evaluated check. A scanner that is watched, running and
    // reporting devices is refreshed and re-armed; one that is watched and running but
    // reports nothing is silent once its quiet time reaches the threshold.
    function automatic void probe_radio(input logic watched, input logic active,
                                        input logic seen, input logic [31:0] now_ms,
                                        inout logic [31:0] last_seen, inout logic sent,
                                        output logic silent, output logic [31:0] secs);
        logic [31:0] quiet_ms;
        silent = 1'b0;
        secs   = '0;
        if (watched && active) begin
            if (seen) begin
                last_seen = now_ms;
                sent      = 1'b0;
            end else begin
                // The difference is taken modulo 2^32, so a wrapped timer still counts right.
                quiet_ms = now_ms - last_seen;
                secs     = quiet_ms / MS_PER_SECOND;
                silent   = quiet_ms >= cfg_threshold;
            end
        end
    endfunction

    // Advances the predictor by one accepted item and returns the status it must produce.
    function automatic monitor_status_t predict_status(input radio_item_t it);
        monitor_status_t res;
        logic            wifi_mute, ble_mute;
        logic [31:0]     wifi_secs, ble_secs, longest;
        logic [1:0]      kind;
        res     = '0;
        kind    = rstm_pkg::KIND_NONE;
        longest = '0;
        case (it.op)
            rstm_pkg::OP_START: begin
                // A second start while already running changes nothing.
                if (!st_running) begin
                    st_running   = 1'b1;
                    st_active    = 1'b0;
                    st_kind      = rstm_pkg::KIND_NONE;
                    st_silence   = '0;
                    st_epoch     = '0;
                    st_published = 1'b0;
                    st_wifi_last = it.now_ms;
                    st_ble_last  = it.now_ms;
                end
            end
            rstm_pkg::OP_CLEAR: begin
                // The operator clear works whether or not the monitor was started.
                st_active    = 1'b0;
                st_kind      = rstm_pkg::KIND_NONE;
                st_wifi_sent = 1'b0;
                st_ble_sent  = 1'b0;
            end
            rstm_pkg::OP_CHECK: begin
                // A last check time of zero never holds a check back on the interval.
                if (st_running && (st_last_check == 0 ||
                                   it.now_ms - st_last_check >= cfg_interval)) begin
                    // The check time moves on even when the boot holdoff skips the check.
                    st_last_check = it.now_ms;
                    if (it.now_ms >= cfg_holdoff) begin
                        res.ran = 1'b1;
                        checks_evaluated++;
                        probe_radio(cfg_watch_wifi, it.wifi_active, it.wifi_seen, it.now_ms,
                                    st_wifi_last, st_wifi_sent, wifi_mute, wifi_secs);
                        probe_radio(cfg_watch_ble, it.ble_active, it.ble_seen, it.now_ms,
                                    st_ble_last, st_ble_sent, ble_mute, ble_secs);
                        if (wifi_mute && ble_mute) begin
                            kind    = rstm_pkg::KIND_BOTH;
                            longest = (wifi_secs > ble_secs) ? wifi_secs : ble_secs;
                        end else if (wifi_mute) begin
                            kind    = rstm_pkg::KIND_WIFI;
                            longest = wifi_secs;
                        end else if (ble_mute) begin
                            kind    = rstm_pkg::KIND_BLE;
                            longest = ble_secs;
                        end
                        if (kind != rstm_pkg::KIND_NONE) begin
                            // Each scanner raises its alert once until it is heard again
                            // or the operator clears it.
                            if (kind == rstm_pkg::KIND_WIFI && !st_wifi_sent) begin
                                st_wifi_sent = 1'b1;
                                res.raised   = 1'b1;
                            end else if (kind == rstm_pkg::KIND_BLE && !st_ble_sent) begin
                                st_ble_sent = 1'b1;
                                res.raised  = 1'b1;
                            end else if (kind == rstm_pkg::KIND_BOTH &&
                                         (!st_wifi_sent || !st_ble_sent)) begin
                                st_wifi_sent = 1'b1;
                                st_ble_sent  = 1'b1;
                                res.raised   = 1'b1;
                            end
                            st_kind    = kind;
                            st_silence = longest[22:0];
                            st_epoch   = it.epoch_s;
                            st_active  = 1'b1;
                            if (res.raised) begin
                                st_published = 1'b1;
                                alerts_raised++;
                            end
                        end else if (st_active) begin
                            // Both scanners are fine again: the alert is dropped.
                            st_active = 1'b0;
                            st_kind   = rstm_pkg::KIND_NONE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.on    = st_active;
        res.kind  = st_active ? st_kind : rstm_pkg::KIND_NONE;
        res.secs  = st_silence;
        res.epoch = st_epoch;
        res.ever  = st_published;
        return res;
    endfunction

    function automatic monitor_status_t status_of(input logic ran, input logic raised,
                                                  input logic on, input logic [1:0] kind,
                                                  input logic [22:0] secs,
                                                  input logic [31:0] epoch, input logic ever);
        monitor_status_t res;
        res.ran    = ran;
        res.raised = raised;
        res.on     = on;
        res.kind   = kind;
        res.secs   = secs;
        res.epoch  = epoch;
        res.ever   = ever;
        return res;
    endfunction

    // radio holds {ble_seen, ble_active, wifi_seen, wifi_active}, the order of the tdata bits.
    task automatic add_row(input logic [1:0] op, input logic [31:0] now_ms,
                           input logic [31:0] epoch_s, input logic [3:0] radio,
                           input logic has_want, input monitor_status_t want);
        table_row_t row;
        row.stim.op          = op;
        row.stim.now_ms      = now_ms;
        row.stim.epoch_s     = epoch_s;
        row.stim.wifi_active = radio[0];
        row.stim.wifi_seen   = radio[1];
        row.stim.ble_active  = radio[2];
        row.stim.ble_seen    = radio[3];
        row.has_want         = has_want;
        row.want             = want;
        stimulus_table.push_back(row);
    endtask

    // Presents one item and returns at the edge where it was taken. The valid stays high,
    // so a following call continues the burst without a bubble.
    task automatic send_item(input radio_item_t it);
        s_tdata  <= {4'b0000, it.ble_seen, it.ble_active, it.wifi_seen, it.wifi_active,
                     it.epoch_s, it.now_ms};
        s_tuser  <= it.op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // The sender works in bursts; when one ends it drops valid for a short random pause.
    task automatic idle_sender();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            // Now and then a long burst, so that stretches with no gaps occur as well.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Holds the sender back until every predicted status has come out, then lets the
    // pipeline settle before anything else happens.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves valid high; the caller drops it once the last register is written.
    task automatic write_reg(input logic [rstm_pkg::CFG_IDX_W-1:0] index,
                             input logic [31:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // One randomized phase under one register setting. The timer advances by random steps
    // of up to step_max ms from first_ms on, so that the interval, holdoff and threshold can be
    // crossed in the normal course; a few checks jump to a random time instead.
    task automatic run_phase(input logic program_regs, input logic [31:0] threshold_ms,
                             input logic [31:0] interval_ms, input logic wifi_on,
                             input logic ble_on, input logic [31:0] holdoff_ms,
                             input logic [31:0] first_ms, input int unsigned step_max,
                             input int unsigned count);
        radio_item_t it;
        int unsigned useful;
        int unsigned pick;
        logic        paused;
        wait_until_idle();
        if (program_regs) begin
            write_reg(rstm_pkg::REG_SILENCE_THRESHOLD, threshold_ms);
            write_reg(rstm_pkg::REG_CHECK_INTERVAL, interval_ms);
            write_reg(rstm_pkg::REG_WATCH_WIFI, {31'b0, wifi_on});
            write_reg(rstm_pkg::REG_WATCH_BLE, {31'b0, ble_on});
            write_reg(rstm_pkg::REG_BOOT_HOLDOFF, holdoff_ms);
            cfg_valid      <= 1'b0;
            cfg_threshold  = threshold_ms;
            cfg_interval   = interval_ms;
            cfg_watch_wifi = wifi_on;
            cfg_watch_ble  = ble_on;
            cfg_holdoff    = holdoff_ms;
            settings_used++;
        end
        clock_ms = first_ms;
        useful   = 0;
        paused   = 1'b0;
        while (useful < count) begin
            // Halfway through, the sender stops until the block has answered everything.
            if (!paused && useful >= count / 2) begin
                paused = 1'b1;
                wait_until_idle();
            end
            pick     = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 19) == 0)
                wifi_quiet = !wifi_quiet;
            if ($urandom_range(0, 19) == 0)
                ble_quiet = !ble_quiet;
            if (pick < 84)
                it.op = rstm_pkg::OP_CHECK;
            else if (pick < 90)
                it.op = rstm_pkg::OP_CLEAR;
            else if (pick < 93)
                it.op = rstm_pkg::OP_START;
            else if (pick < 95)
                it.op = OP_RESERVED;
            else
                it.op = rstm_pkg::OP_CHECK;
            it.now_ms      = (pick >= 95) ? $urandom : clock_ms;
            it.epoch_s     = $urandom;
            it.wifi_active = $urandom_range(0, 9) != 0;
            it.wifi_seen   = wifi_quiet ? ($urandom_range(0, 19) == 0)
                                        : ($urandom_range(0, 3) != 0);
            it.ble_active  = $urandom_range(0, 9) != 0;
            it.ble_seen    = ble_quiet ? ($urandom_range(0, 19) == 0)
                                       : ($urandom_range(0, 3) != 0);
            send_item(it);
            expected_status.push_back(predict_status(it));
            // Starts and the reserved op do not count toward the length of the phase; starts after
            // the first one and the reserved op do nothing.
            if (it.op == rstm_pkg::OP_CHECK || it.op == rstm_pkg::OP_CLEAR)
                useful++;
            idle_sender();
        end
    endtask

    // Result side: every status taken from the block is compared field by field with the
    // oldest prediction. The ready is held high, random, mostly low or in a fixed gap pattern, by turns.
    always @(posedge aclk) begin : result_side
        monitor_status_t got;
        monitor_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ran    = m_tdata[rstm_pkg::M_RAN_BIT];
            got.raised = m_tdata[rstm_pkg::M_RAISED_BIT];
            got.on     = m_tdata[rstm_pkg::M_ON_BIT];
            got.kind   = m_tdata[rstm_pkg::M_KIND_LSB +: 2];
            got.secs   = m_tdata[rstm_pkg::M_SECS_LSB +: rstm_pkg::SECS_W];
            got.epoch  = m_tdata[rstm_pkg::M_EPOCH_LSB +: 32];
            got.ever   = m_tdata[rstm_pkg::M_EVER_BIT];
            if (expected_status.size() == 0) begin
                report_error($sformatf("status 0x%0h arrived with no item outstanding",
                                       m_tdata));
            end else begin
                want = expected_status.pop_front();
                compare_field("check_ran", got.ran, want.ran);
                compare_field("alert_raised", got.raised, want.raised);
                compare_field("alert_on", got.on, want.on);
                compare_field("alert_kind", got.kind, want.kind);
                compare_field("silence_seconds", got.secs, want.secs);
                compare_field("alert_epoch", got.epoch, want.epoch);
                compare_field("ever_published", got.ever, want.ever);
                compare_field("padding",
                              m_tdata[rstm_pkg::M_DATA_W-1:rstm_pkg::M_EVER_BIT+1], '0);
                results_checked++;
            end
        end
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[4:3] != 2'd2);
        endcase
    end

    // Watchdog: a long stretch with no handshake on any channel means the block is stuck.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d statuses outstanding.",
                     idle_cycles, expected_status.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        table_row_t      row;
        monitor_status_t predicted;

        // Directed part, all under the reset values of the registers: threshold 300 s,
        // interval 30 s, both scanners watched, boot holdoff 120 s.
        // Before the monitor is started, checks, clears and the reserved op do nothing.
        add_row(rstm_pkg::OP_CHECK, 32'd5000, 32'd1, 4'b1111, 1'b1, '0);
        add_row(rstm_pkg::OP_CLEAR, 32'd0, 32'd0, 4'b0000, 1'b1, '0);
        add_row(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1111, 1'b1, '0);
        // Start at 1 s: both scanners count as seen at that moment.
        add_row(rstm_pkg::OP_START, 32'd1000, 32'd7, 4'b0000, 1'b1, '0);
        // First check, inside the holdoff: skipped, but the check time is taken.
        add_row(rstm_pkg::OP_CHECK, 32'd50000, 32'd8, 4'b0101, 1'b1, '0);
        // Only 10 s later: the interval holds it back.
        add_row(rstm_pkg::OP_CHECK, 32'd60000, 32'd9, 4'b0101, 1'b1, '0);
        // Past the holdoff, both scanners report devices: evaluated, no alert.
        add_row(rstm_pkg::OP_CHECK, 32'd130000, 32'd10, 4'b1111, 1'b1,
                status_of(1'b1, 1'b0, 1'b0, rstm_pkg::KIND_NONE, 23'd0, 32'd0, 1'b0));
        // Wifi quiet for 310 s: a wifi alert is raised.
        add_row(rstm_pkg::OP_CHECK, 32'd440000, 32'h1234_5678, 4'b1101, 1'b1,
                status_of(1'b1, 1'b1, 1'b1, rstm_pkg::KIND_WIFI, 23'd310, 32'h1234_5678,
                          1'b1));
        // Still quiet: the alert is updated but not raised a second time.
        add_row(rstm_pkg::OP_CHECK, 32'd480000, 32'hFFFF_FFFF, 4'b1101, 1'b1,
                status_of(1'b1, 1'b0, 1'b1, rstm_pkg::KIND_WIFI, 23'd350, 32'hFFFF_FFFF,
                          1'b1));
        // Both quiet; ble has not alerted yet, so the combined alert is raised.
        add_row(rstm_pkg::OP_CHECK, 32'd800000, 32'hA5A5_5A5A, 4'b0101, 1'b1,
                status_of(1'b1, 1'b1, 1'b1, rstm_pkg::KIND_BOTH, 23'd670, 32'hA5A5_5A5A,
                          1'b1));
        // Both heard again: the alert goes away, the stored values stay.
        add_row(rstm_pkg::OP_CHECK, 32'd840000, 32'd11, 4'b1111, 1'b1,
                status_of(1'b1, 1'b0, 1'b0, rstm_pkg::KIND_NONE, 23'd670, 32'hA5A5_5A5A,
                          1'b1));
        add_row(rstm_pkg::OP_CLEAR, 32'd840001, 32'd12, 4'b0000, 1'b1,
                status_of(1'b0, 1'b0, 1'b0, rstm_pkg::KIND_NONE, 23'd670, 32'hA5A5_5A5A,
                          1'b1));
        // From here on the predictor supplies the expected status.
        // Wifi scanner stopped while ble goes quiet, then a ble-only alert.
        add_row(rstm_pkg::OP_CHECK, 32'd900000, 32'd13, 4'b0100, 1'b0, '0);
        add_row(rstm_pkg::OP_CHECK, 32'd1300000, 32'd14, 4'b0100, 1'b0, '0);
        // Start while already running.
        add_row(rstm_pkg::OP_START, 32'd7, 32'd15, 4'b1111, 1'b0, '0);
        // The timer wraps between these two checks; silence is measured across the wrap.
        add_row(rstm_pkg::OP_CHECK, 32'hFFFF_0000, 32'd16, 4'b1111, 1'b0, '0);
        add_row(rstm_pkg::OP_CHECK, 32'h0005_0000, 32'd17, 4'b0101, 1'b0, '0);
        // A check at time zero leaves a zero check time, so the next one is due at once.
        add_row(rstm_pkg::OP_CHECK, 32'd0, 32'd0, 4'b0000, 1'b0, '0);
        add_row(rstm_pkg::OP_CHECK, 32'd10, 32'd18, 4'b0000, 1'b0, '0);
        // No scanner running: nothing can be silent, the active alert is dropped.
        add_row(rstm_pkg::OP_CHECK, 32'h0002_0000, 32'd19, 4'b0000, 1'b0, '0);
        // Devices reported by stopped scanners, then the reserved op once more.
        add_row(rstm_pkg::OP_CLEAR, 32'h0002_0001, 32'd20, 4'b1010, 1'b0, '0);
        add_row(OP_RESERVED, 32'd0, 32'd0, 4'b0000, 1'b0, '0);

        // Reset is held at the start and released once.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stimulus_table[i]) begin
            row = stimulus_table[i];
            send_item(row.stim);
            predicted = predict_status(row.stim);
            expected_status.push_back(row.has_want ? row.want : predicted);
            idle_sender();
        end

        // Random phases. The first keeps the reset values; the others move through small
        // settings, the lowest and highest register values, a timer wrap, a holdoff at
        // half the timer range, and both scanners unwatched.
        run_phase(1'b0, rstm_pkg::SILENCE_THRESHOLD_RST, rstm_pkg::CHECK_INTERVAL_RST,
                  1'b1, 1'b1, rstm_pkg::BOOT_HOLDOFF_RST, 32'd2000000, 40000, 400);
        run_phase(1'b1, 32'd5000, 32'd1000, 1'b1, 1'b1, 32'd3000,
                  32'hFFFF_C000, 2500, 400);
        run_phase(1'b1, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0, 32'd500, 100, 250);
        run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF,
                  32'hFFFF_FF00, 20, 150);
        run_phase(1'b1, 32'd20000, 32'd5000, 1'b1, 1'b1, 32'h8000_0000,
                  32'h7FFF_0000, 8000, 300);
        run_phase(1'b1, 32'd1000, 32'd500, 1'b0, 1'b0, 32'd0, 32'd100, 1000, 100);

        wait_until_idle();

        $display("Sent %0d items under %0d register settings, timer wrap included.",
                 items_sent, settings_used);
        $display("%0d checks evaluated, %0d alerts raised, %0d statuses compared.",
                 checks_evaluated, alerts_raised, results_checked);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/rstm_pkg.sv
sv/radio_silence_tamper_monitor.sv
sv/rstm_checker.sv
tb/sv/tb_radio_silence_tamper_monitor.sv
